>>> hdl/nlsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlsd_pkg
// Shared types and fixed constants for the neighbor list sort/dedup block.
// ----------------------------------------------------------------------------
package nlsd_pkg;

   // request opcodes
   localparam logic OP_DEG_WRITE = 1'b0;
   localparam logic OP_PUSH      = 1'b1;

   // fixed field widths
   localparam int DEG_IN_BITS = 16;
   localparam int DUP_BITS    = 5;
   localparam logic [DUP_BITS-1:0] DUP_MAX = '1;

   // qualifiers for the shared key compare unit
   typedef struct packed {
      logic cand_vld;
      logic best_vld;
      logic bound_vld;
   } cmp_ctl_type;

endpackage

>>> hdl/neighbor_list_sort_dedup_by_degree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_list_sort_dedup_by_degree
// Degree table plus neighbor list; emits each list's unique ids by degree.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of the degree table and holds
// req_ready low meanwhile. A degree write or a push without last_of_list
// is taken while the block stays idle. A push with last_of_list starts a
// selection pass loop: each pass streams the N held ids through the list
// buffer, the degree table read port and one shared key compare unit, and
// picks the largest {degree, id} key below the one found by the previous
// pass, so equal ids fall out on their own. A pass issues the N reads, lets
// the read pipeline drain, and then takes the pass result once the output
// register is free. A list with U unique ids takes U+1 passes, and
// req_ready comes back when the final result enters the output register.
// The output register lets the next item be taken while the final result
// of a list is still waiting.
// ----------------------------------------------------------------------------
module neighbor_list_sort_dedup_by_degree
   import nlsd_pkg::*;
#(
   parameter int VERTEX_BITS = 10,
   parameter int LIST_MAX    = 32,
   parameter int DEGREE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   input  logic [VERTEX_BITS-1:0] req_vertex,
   input  logic [DEG_IN_BITS-1:0] req_degree_value,
   input  logic                   req_last_of_list,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VERTEX_BITS-1:0] rsp_neighbor,
   output logic [DUP_BITS-1:0]    rsp_duplicates_removed,
   output logic                   rsp_overflow,
   output logic                   rsp_last_result
);

   localparam int CNT_W    = $clog2(LIST_MAX + 1);
   localparam int IDX_W    = $clog2(LIST_MAX);
   localparam int KEY_W    = DEGREE_BITS + VERTEX_BITS;
   localparam int SAT_W    = (DEGREE_BITS > DEG_IN_BITS) ? DEGREE_BITS : DEG_IN_BITS;
   localparam int DIFF_W   = (CNT_W > DUP_BITS) ? CNT_W : DUP_BITS;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_SCAN  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       uniq_ff, uniq_in;
   logic                   p1_ff, p1_in;
   logic                   p2_ff;
   logic [VERTEX_BITS-1:0] v2_ff;
   logic [KEY_W-1:0]       best_ff, best_in;
   logic                   best_vld_ff, best_vld_in;
   logic [KEY_W-1:0]       pend_ff, pend_in;
   logic                   pend_vld_ff, pend_vld_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_BITS-1:0] rsp_neighbor_ff, rsp_neighbor_in;
   logic [DUP_BITS-1:0]    rsp_dups_ff, rsp_dups_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;
   logic                   rsp_last_ff, rsp_last_in;

   // list buffer
   logic [VERTEX_BITS-1:0] lb_mem [LIST_MAX];
   logic [VERTEX_BITS-1:0] lb_rd_ff;
   logic                   lb_we;

   // degree table
   logic                   deg_we;
   logic [DEGREE_BITS-1:0] deg_wr_data;
   logic [DEGREE_BITS-1:0] deg_rd_data;
   logic                   deg_busy;
   logic [SAT_W-1:0]       deg_wide;
   logic [SAT_W-1:0]       deg_max_wide;

   // compare unit
   cmp_ctl_type            cmp_ctl;
   logic [KEY_W-1:0]       cand;
   logic                   take;

   logic                   out_free;
   logic                   issuing;
   logic [DIFF_W-1:0]      diff_w;
   logic [DUP_BITS-1:0]    dups_sat;

   // degree saturation to the table width
   assign deg_wide     = SAT_W'(req_degree_value);
   assign deg_max_wide = SAT_W'({DEGREE_BITS{1'b1}});
   always_comb begin
      if (deg_wide > deg_max_wide) begin
         deg_wr_data = DEGREE_BITS'(deg_max_wide);
      end else begin
         deg_wr_data = DEGREE_BITS'(deg_wide);
      end
   end

   nlsd_deg_store #(
      .ADDR_BITS (VERTEX_BITS),
      .DATA_BITS (DEGREE_BITS)
   ) u_deg_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (deg_we),
      .wr_addr (req_vertex),
      .wr_data (deg_wr_data),
      .rd_addr (lb_rd_ff),
      .rd_data (deg_rd_data),
      .busy    (deg_busy)
   );

   assign cand              = {deg_rd_data, v2_ff};
   assign cmp_ctl.cand_vld  = p2_ff;
   assign cmp_ctl.best_vld  = best_vld_ff;
   assign cmp_ctl.bound_vld = pend_vld_ff;

   nlsd_key_cmp #(
      .KEY_BITS (KEY_W)
   ) u_key_cmp (
      .ctl   (cmp_ctl),
      .cand  (cand),
      .best  (best_ff),
      .bound (pend_ff),
      .take  (take)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign issuing  = (state_ff == S_SCAN) && (idx_ff < count_ff);
   assign p1_in    = issuing;

   assign diff_w = DIFF_W'(count_ff - uniq_ff);
   always_comb begin
      if (diff_w > DIFF_W'(DUP_MAX)) begin
         dups_sat = DUP_MAX;
      end else begin
         dups_sat = DUP_BITS'(diff_w);
      end
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      ovf_in          = ovf_ff;
      idx_in          = idx_ff;
      uniq_in         = uniq_ff;
      best_in         = best_ff;
      best_vld_in     = best_vld_ff;
      pend_in         = pend_ff;
      pend_vld_in     = pend_vld_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_neighbor_in = rsp_neighbor_ff;
      rsp_dups_in     = rsp_dups_ff;
      rsp_ovf_in      = rsp_ovf_ff;
      rsp_last_in     = rsp_last_ff;
      lb_we           = 1'b0;
      deg_we          = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            if (!deg_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_DEG_WRITE) begin
                  deg_we = 1'b1;
               end else begin
                  if (count_ff < CNT_W'(LIST_MAX)) begin
                     lb_we    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_last_of_list) begin
                     state_in    = S_SCAN;
                     idx_in      = '0;
                     uniq_in     = '0;
                     best_vld_in = 1'b0;
                     pend_vld_in = 1'b0;
                  end
               end
            end
         end
         S_SCAN: begin
            if (issuing) begin
               idx_in = idx_ff + 1'b1;
            end else if (!p1_ff && !p2_ff) begin
               state_in = S_DONE;
            end
            if (take) begin
               best_in     = cand;
               best_vld_in = 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               if (best_vld_ff) begin
                  // a new key was found: the pending one is not the last
                  if (pend_vld_ff) begin
                     rsp_valid_in    = 1'b1;
                     rsp_neighbor_in = pend_ff[VERTEX_BITS-1:0];
                     rsp_dups_in     = '0;
                     rsp_ovf_in      = 1'b0;
                     rsp_last_in     = 1'b0;
                  end
                  pend_in     = best_ff;
                  pend_vld_in = 1'b1;
                  best_vld_in = 1'b0;
                  uniq_in     = uniq_ff + 1'b1;
                  idx_in      = '0;
                  state_in    = S_SCAN;
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_neighbor_in = pend_ff[VERTEX_BITS-1:0];
                  rsp_dups_in     = dups_sat;
                  rsp_ovf_in      = ovf_ff;
                  rsp_last_in     = 1'b1;
                  count_in        = '0;
                  ovf_in          = 1'b0;
                  state_in        = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         uniq_ff      <= '0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         best_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         uniq_ff      <= uniq_in;
         p1_ff        <= p1_in;
         p2_ff        <= p1_ff;
         best_vld_ff  <= best_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff         <= best_in;
      pend_ff         <= pend_in;
      v2_ff           <= lb_rd_ff;
      rsp_neighbor_ff <= rsp_neighbor_in;
      rsp_dups_ff     <= rsp_dups_in;
      rsp_ovf_ff      <= rsp_ovf_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (lb_we) begin
         lb_mem[count_ff[IDX_W-1:0]] <= req_vertex;
      end
      lb_rd_ff <= lb_mem[idx_ff[IDX_W-1:0]];
   end

   assign req_ready              = (state_ff == S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_neighbor           = rsp_neighbor_ff;
   assign rsp_duplicates_removed = rsp_dups_ff;
   assign rsp_overflow           = rsp_ovf_ff;
   assign rsp_last_result        = rsp_last_ff;

endmodule

>>> hdl/nlsd_deg_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlsd_deg_store
// Degree table: one write port, one registered read port, and a clearing
// pass after reset that zeroes every entry, one per cycle.
// ----------------------------------------------------------------------------
module nlsd_deg_store #(
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data,
   output logic                 busy
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                 clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {ADDR_BITS{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

>>> hdl/nlsd_key_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlsd_key_cmp
// Shared compare unit: takes a candidate {degree, id} key if it is below
// the bound (the previous pass's key) and above this pass's best key.
// ----------------------------------------------------------------------------
module nlsd_key_cmp
   import nlsd_pkg::*;
#(
   parameter int KEY_BITS = 26
) (
   input  cmp_ctl_type         ctl,
   input  logic [KEY_BITS-1:0] cand,
   input  logic [KEY_BITS-1:0] best,
   input  logic [KEY_BITS-1:0] bound,
   output logic                take
);

   logic below_bound;
   logic above_best;

   // strictly below the bound drops repeats of an emitted id
   assign below_bound = !ctl.bound_vld || (cand < bound);
   assign above_best  = !ctl.best_vld  || (cand > best);
   assign take        = ctl.cand_vld && below_bound && above_best;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the neighbor list sort/dedup block.
// Loads degrees and neighbor lists over the request channel, predicts the
// degree-ordered unique neighbors of every closed list, and compares each
// result item against the oldest prediction. The run covers several
// sender/receiver idle mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top
   import nlsd_pkg::*;
();

   localparam int VTX_W       = 10;
   localparam int LIST_CAP    = 32;
   localparam int NUM_VTX     = 1 << VTX_W;
   localparam int STALL_LIMIT = 20000;
   localparam int REPORT_MAX  = 10;

   typedef struct {
      logic [VTX_W-1:0]    nbr;
      logic [DUP_BITS-1:0] dups;
      logic                ovf;
      logic                fin;
   } nbr_result_type;

   // Degree table, open list and the queue of neighbors still owed by the block.
   class degree_order_board;
      bit [DEG_IN_BITS-1:0] deg_table [NUM_VTX];
      bit [VTX_W-1:0]       held_ids [LIST_CAP];
      int                   held_cnt = 0;
      bit                   push_lost = 0;
      nbr_result_type       due_neighbors [$];
      int                   mismatches = 0;
      int                   results_seen = 0;
      int                   lists_closed = 0;
      int                   full_lists = 0;

      function bit ranks_above(bit [VTX_W-1:0] a, bit [VTX_W-1:0] b);
         if (deg_table[a] != deg_table[b])
            return deg_table[a] > deg_table[b];
         return a > b;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("%s", msg);
      endfunction

      function void take_request(bit op, bit [VTX_W-1:0] vtx, bit [DEG_IN_BITS-1:0] dval,
                                 bit last);
         bit [VTX_W-1:0] ord [LIST_CAP];
         bit [VTX_W-1:0] key;
         nbr_result_type r;
         int             i, j, uniq, dups;
         if (op == OP_DEG_WRITE) begin
            deg_table[vtx] = dval;
            return;
         end
         if (held_cnt < LIST_CAP) begin
            held_ids[held_cnt] = vtx;
            held_cnt++;
         end else begin
            push_lost = 1;
         end
         if (!last)
            return;
         for (i = 0; i < held_cnt; i++) begin
            key = held_ids[i];
            j = i;
            while (j > 0 && ranks_above(key, ord[j-1])) begin
               ord[j] = ord[j-1];
               j--;
            end
            ord[j] = key;
         end
         // equal ids share a degree, so repeats end up adjacent
         uniq = 0;
         for (i = 0; i < held_cnt; i++) begin
            if (uniq == 0 || ord[uniq-1] != ord[i]) begin
               ord[uniq] = ord[i];
               uniq++;
            end
         end
         dups = held_cnt - uniq;
         if (dups > DUP_MAX)
            dups = DUP_MAX;
         for (i = 0; i < uniq; i++) begin
            r.nbr  = ord[i];
            r.fin  = (i == uniq - 1);
            r.dups = r.fin ? dups[DUP_BITS-1:0] : '0;
            r.ovf  = r.fin & push_lost;
            due_neighbors.push_back(r);
         end
         lists_closed++;
         if (push_lost)
            full_lists++;
         held_cnt  = 0;
         push_lost = 0;
      endfunction

      function void check_neighbor(nbr_result_type got);
         nbr_result_type want;
         results_seen++;
         if (due_neighbors.size() == 0) begin
            flag($sformatf("ERROR unexpected item: nbr %0d dups %0d ovf %0d last %0d",
                           got.nbr, got.dups, got.ovf, got.fin));
            return;
         end
         want = due_neighbors.pop_front();
         if (got.nbr !== want.nbr || got.dups !== want.dups || got.ovf !== want.ovf ||
             got.fin !== want.fin)
            flag($sformatf({"ERROR item %0d: expected nbr %0d dups %0d ovf %0d last %0d,",
                            " got nbr %0d dups %0d ovf %0d last %0d"}, results_seen,
                           want.nbr, want.dups, want.ovf, want.fin,
                           got.nbr, got.dups, got.ovf, got.fin));
      endfunction

      function void flush_leftover();
         nbr_result_type want;
         while (due_neighbors.size() != 0) begin
            want = due_neighbors.pop_front();
            flag($sformatf("ERROR missing item: nbr %0d dups %0d ovf %0d last %0d",
                           want.nbr, want.dups, want.ovf, want.fin));
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_opcode;
   logic [VTX_W-1:0]       req_vertex;
   logic [DEG_IN_BITS-1:0] req_degree_value;
   logic                   req_last_of_list;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [VTX_W-1:0]       rsp_neighbor;
   logic [DUP_BITS-1:0]    rsp_duplicates_removed;
   logic                   rsp_overflow;
   logic                   rsp_last_result;

   degree_order_board order_board;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                hold_left = 0;
   int                items_sent = 0;
   bit [VTX_W-1:0]    hot_vtx [8];
   int                idle_mix [4] = '{0, 83, 0, 34};
   int                stall_mix [4] = '{0, 0, 83, 34};

   neighbor_list_sort_dedup_by_degree DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_opcode             (req_opcode),
      .req_vertex             (req_vertex),
      .req_degree_value       (req_degree_value),
      .req_last_of_list       (req_last_of_list),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_neighbor           (rsp_neighbor),
      .rsp_duplicates_removed (rsp_duplicates_removed),
      .rsp_overflow           (rsp_overflow),
      .rsp_last_result        (rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : monitor
      nbr_result_type got;
      if (!reset) begin
         if (req_valid && req_ready === 1'b1)
            order_board.take_request(req_opcode, req_vertex, req_degree_value,
                                     req_last_of_list);
         if (rsp_valid === 1'b1 && rsp_ready) begin
            got.nbr  = rsp_neighbor;
            got.dups = rsp_duplicates_removed;
            got.ovf  = rsp_overflow;
            got.fin  = rsp_last_result;
            order_board.check_neighbor(got);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   task automatic offer_item(bit op, bit [VTX_W-1:0] vtx, bit [DEG_IN_BITS-1:0] dval,
                             bit last);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_vertex       <= vtx;
      req_degree_value <= dval;
      req_last_of_list <= last;
      @(posedge clock);
      while (req_ready !== 1'b1)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // sender pauses until every owed neighbor has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (order_board.due_neighbors.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic bit [VTX_W-1:0] pick_vertex();
      if ($urandom_range(9) < 7)
         return hot_vtx[$urandom_range(7)];
      return VTX_W'($urandom_range(NUM_VTX - 1));
   endfunction

   // favor the extremes and tiny values so that degree ties are common
   function automatic bit [DEG_IN_BITS-1:0] pick_degree();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return DEG_IN_BITS'($urandom_range(3));
         default: return DEG_IN_BITS'($urandom_range(65535));
      endcase
   endfunction

   task automatic send_list(int len, bit one_id);
      bit [VTX_W-1:0] id;
      int             i;
      id = pick_vertex();
      for (i = 0; i < len; i++) begin
         if ($urandom_range(4) == 0)
            offer_item(OP_DEG_WRITE, pick_vertex(), pick_degree(), 1'($urandom_range(1)));
         offer_item(OP_PUSH, one_id ? id : pick_vertex(),
                    DEG_IN_BITS'($urandom_range(65535)), i == len - 1);
      end
   endtask

   initial begin
      int p, start;
      order_board      = new;
      req_valid        = 1'b0;
      req_opcode       = OP_DEG_WRITE;
      req_vertex       = '0;
      req_degree_value = '0;
      req_last_of_list = 1'b0;
      reset            = 1'b1;
      foreach (hot_vtx[k])
         hot_vtx[k] = VTX_W'($urandom_range(NUM_VTX - 1));
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lone neighbor on an all-zero table
      offer_item(OP_PUSH, 10'd1023, 16'hFFFF, 1'b1);
      // last_of_list is ignored on degree writes
      offer_item(OP_DEG_WRITE, 10'd1023, 16'hFFFF, 1'b1);
      offer_item(OP_DEG_WRITE, 10'd5, 16'hFFFF, 1'b0);
      offer_item(OP_DEG_WRITE, 10'd0, 16'h0000, 1'b1);
      offer_item(OP_DEG_WRITE, 10'd7, 16'h0001, 1'b0);
      offer_item(OP_DEG_WRITE, 10'd512, 16'h8000, 1'b0);
      // top-degree tie broken by id, plus repeats
      offer_item(OP_PUSH, 10'd5, 16'h0000, 1'b0);
      offer_item(OP_PUSH, 10'd1023, 16'h5555, 1'b0);
      offer_item(OP_PUSH, 10'd0, 16'hAAAA, 1'b0);
      offer_item(OP_PUSH, 10'd7, 16'h0000, 1'b0);
      offer_item(OP_PUSH, 10'd5, 16'hFFFF, 1'b0);
      offer_item(OP_PUSH, 10'd0, 16'h0000, 1'b0);
      offer_item(OP_PUSH, 10'd512, 16'h1234, 1'b0);
      offer_item(OP_PUSH, 10'd1023, 16'h0000, 1'b1);
      // a lowered degree must reorder later lists
      offer_item(OP_DEG_WRITE, 10'd5, 16'h0000, 1'b0);
      offer_item(OP_PUSH, 10'd5, 16'h0000, 1'b0);
      offer_item(OP_PUSH, 10'd7, 16'h0000, 1'b0);
      offer_item(OP_PUSH, 10'd5, 16'h0000, 1'b1);
      offer_item(OP_PUSH, 10'd0, 16'hFFFF, 1'b1);
      settle();

      for (p = 0; p < 4; p++) begin
         send_idle_pct  = idle_mix[p];
         recv_stall_pct = stall_mix[p];
         if (p == 0) begin
            // receiver holds off while lists keep coming, so the input backs up
            @(posedge clock);
            hold_left = 600;
            @(negedge clock);
            send_list(8, 1'b0);
            send_list(6, 1'b0);
            settle();
            // buffer fills: one push dropped mid-list, the closing one dropped too
            send_list(LIST_CAP + 2, 1'b1);
         end
         start = items_sent;
         while (items_sent - start < 6) begin
            repeat ($urandom_range(2))
               offer_item(OP_DEG_WRITE, pick_vertex(), pick_degree(),
                          1'($urandom_range(1)));
            send_list($urandom_range(1, 8), $urandom_range(9) == 0);
         end
         settle();
      end

      order_board.flush_leftover();
      $display("Covered %0d items, %0d lists (%0d with a full buffer), %0d neighbors checked",
               items_sent, order_board.lists_closed, order_board.full_lists,
               order_board.results_seen);
      $display("Idle mixes: none, sparse sender, stalled receiver, both; one long hold-off");
      if (order_board.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> neighbor_list_sort_dedup_by_degree.f
hdl/nlsd_pkg.sv
hdl/nlsd_deg_store.sv
hdl/nlsd_key_cmp.sv
hdl/neighbor_list_sort_dedup_by_degree.sv
test/tb_top.sv
